/* hw/rtl/bsb_pkg.sv */
`default_nettype none
package bsb_pkg;

    localparam int MAX_KNOTS  = 64;
    localparam int MAX_DEGREE = 7;
    localparam int KW  = $clog2(MAX_KNOTS);
    localparam int DW  = 3;
    localparam int LW  = $clog2(MAX_DEGREE + 1);
    localparam int VW  = 40;

    localparam logic [1:0] CFG_DEGREE = 2'd0;
    localparam logic [1:0] CFG_COUNT  = 2'd1;
    localparam logic [1:0] CFG_TOL    = 2'd2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    localparam logic signed [VW-1:0] SAT_HI = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] SAT_LO = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] ONE_Q32 = 40'sh01_0000_0000;

    typedef struct packed {
        logic               req_type;
        logic [5:0]         knot_slot;
        logic signed [31:0] knot_value;
        logic signed [31:0] param_t;
        logic               derivative_order;
    } bsb_in_t;

    typedef struct packed {
        logic                 status;
        logic [5:0]           basis_index;
        logic signed [VW-1:0] basis_value;
        logic                 last;
    } bsb_out_t;

    typedef struct packed {
        logic                 start;
        logic signed [33:0]   num;
        logic signed [VW-1:0] val;
        logic signed [32:0]   den;
    } bsb_md_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [VW-1:0] res;
    } bsb_md_rsp_t;

    function automatic logic signed [VW-1:0] sat40(input logic signed [VW+1:0] v);
        if (v > $signed({{2{1'b0}}, SAT_HI})) return SAT_HI;
        if (v < $signed({{2{1'b1}}, SAT_LO})) return SAT_LO;
        return v[VW-1:0];
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/bsb_muldiv.sv */
`default_nettype none
module bsb_muldiv (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bsb_pkg::bsb_md_req_t req,
    output bsb_pkg::bsb_md_rsp_t    rsp
);
    import bsb_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ML, S_MH, S_CHK, S_DIV, S_FIN} st_t;

    st_t         st_reg;
    logic        neg_reg;
    logic [39:0] a_reg;
    logic [39:0] b_reg;
    logic [32:0] d_reg;
    logic [79:0] prod_reg;
    logic [79:0] rem_reg;
    logic [38:0] q_reg;
    logic [5:0]  cnt_reg;
    logic [VW-1:0] res_reg;
    logic        done_reg;

    logic [33:0] amag;
    logic [39:0] bmag;
    logic [32:0] dmag;
    logic [80:0] trial;

    assign amag = req.num[33] ? 34'(-req.num) : 34'(req.num);
    assign bmag = req.val[VW-1] ? 40'(-req.val) : 40'(req.val);
    assign dmag = req.den[32] ? 33'(-req.den) : 33'(req.den);
    assign trial = {rem_reg, prod_reg[38]} - {48'd0, d_reg};
    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

    // multiply in two 20-bit slices, then restoring division one bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        neg_reg  <= (req.num[33] ^ req.val[VW-1]) ^ req.den[32];
                        a_reg    <= {6'd0, amag};
                        b_reg    <= bmag;
                        d_reg    <= dmag;
                        prod_reg <= 80'(a_reg[0] & 1'b0);
                        st_reg   <= S_ML;
                    end
                end
                S_ML:
                begin
                    prod_reg <= 80'(a_reg * b_reg[19:0]);
                    st_reg   <= S_MH;
                end
                S_MH:
                begin
                    prod_reg <= prod_reg + {60'(a_reg * b_reg[39:20]), 20'd0} ;
                    st_reg   <= S_CHK;
                end
                S_CHK:
                begin
                    if (a_reg == 40'd0 || b_reg == 40'd0)
                    begin
                        res_reg <= '0;
                        st_reg  <= S_FIN;
                    end
                    else if (prod_reg[79:39] >= {8'd0, d_reg})
                    begin
                        res_reg <= neg_reg ? SAT_LO : SAT_HI;
                        st_reg  <= S_FIN;
                    end
                    else
                    begin
                        rem_reg  <= {39'd0, prod_reg[79:39]};
                        q_reg    <= '0;
                        cnt_reg  <= 6'd38;
                        st_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (!trial[80])
                    begin
                        rem_reg <= trial[79:0];
                        q_reg   <= {q_reg[37:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[78:0], prod_reg[38]};
                        q_reg   <= {q_reg[37:0], 1'b0};
                    end
                    prod_reg <= {prod_reg[79:39], prod_reg[37:0], 1'b0};
                    if (cnt_reg == 6'd0)
                        st_reg <= S_FIN;
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                end
                S_FIN:
                begin
                    if (a_reg != 40'd0 && b_reg != 40'd0
                        && prod_reg[79:39] < {8'd0, d_reg})
                        res_reg <= neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
                    done_reg <= 1'b1;
                    st_reg   <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/bspline_basis_evaluator_unit.sv */
`default_nettype none
// operation: a load item writes the knot memory; an evaluate item runs the span
//   search over the knots, then up to 2*d*(d+1) multiply-divides, then emits
//   the results one basis index at a time
// throughput: one item at a time; the serial divider and the knot memory
//   read port set the figure; the receiver cannot stall
// reset: registers to 3/0/1, knot memory and layer buffer undefined until written
module bspline_basis_evaluator_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire bsb_pkg::bsb_in_t   in_item,
    output logic                    busy,
    output logic                    result_valid,
    output bsb_pkg::bsb_out_t       result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import bsb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK0, S_CHK1, S_CHK2, S_SRCH0, S_SRCH1, S_SRCH2,
        S_TOP0, S_TOP1, S_TOP2, S_WIN, S_CLR, S_TERM0, S_TERM1, S_TERM2,
        S_TERM3, S_MD, S_WB, S_OUT, S_OUT1
    } st_t;

    logic [2:0]  deg_reg;
    logic [6:0]  cnt_reg;
    logic [15:0] tol_reg;

    // knot memory, one read port, registered data
    logic signed [31:0] kmem [MAX_KNOTS];
    logic [KW-1:0]      kaddr;
    logic signed [31:0] kq_reg;
    logic               kwe;

    // layer buffer memory
    logic signed [VW-1:0] lmem [MAX_DEGREE+1];
    logic [LW-1:0]        laddr;
    logic                 lwe;
    logic signed [VW-1:0] lwd;
    logic signed [VW-1:0] lq_reg;

    st_t   st_reg;
    logic signed [31:0] t_reg;
    logic  der_reg;
    logic [6:0] n_reg;
    logic [2:0] d_reg;
    logic [6:0] i_reg;
    logic [6:0] k_reg;
    logic [6:0] base_reg;
    logic [3:0] width_reg;
    logic [2:0] p_reg;
    logic       side_reg;
    logic signed [31:0] ka_reg;
    logic signed [31:0] kb_reg;
    logic       found_reg;
    logic signed [VW+1:0] acc_reg;
    logic signed [VW-1:0] left_reg;
    logic       ovalid_reg;
    bsb_out_t   out_reg;

    bsb_md_req_t mreq;
    bsb_md_rsp_t mrsp;

    logic [6:0] g;
    logic [6:0] ga;
    logic [6:0] gb;
    logic       dstep;
    logic signed [32:0] diff;
    logic signed [32:0] dfk;
    logic signed [32:0] tol_s;
    logic       small_d;
    logic [6:0] nb;

    function automatic logic is_small(input logic signed [32:0] x, input logic [15:0] tl);
        logic [32:0] m;
        m = x[32] ? 33'(-x) : 33'(x);
        return (x == 33'sd0) || (m < {17'd0, tl});
    endfunction

    bsb_muldiv u_md (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    assign busy         = (st_reg != S_IDLE);
    assign cfg_ready    = (st_reg == S_IDLE);
    assign result_valid = ovalid_reg;
    assign result       = out_reg;
    assign tol_s        = {17'd0, tol_reg};
    assign diff         = 33'(kq_reg) - 33'(ka_reg);
    assign dfk          = 33'(kb_reg) - 33'(ka_reg);
    assign small_d      = is_small(diff, tol_reg);
    assign g            = base_reg + i_reg;
    assign dstep        = der_reg && (p_reg == d_reg);
    assign ga           = side_reg ? 7'(g + 7'd1) : g;
    assign gb           = 7'(ga + {4'd0, p_reg});
    assign nb           = n_reg - {4'd0, d_reg} - 7'd1;

    assign kwe = start && !busy && (in_item.req_type == REQ_LOAD);

    always_ff @(posedge clk)
    begin
        if (kwe)
            kmem[in_item.knot_slot[KW-1:0]] <= in_item.knot_value;
        kq_reg <= kmem[kaddr];
        if (lwe)
            lmem[laddr] <= lwd;
        lq_reg <= lmem[laddr];
    end

    // sequencer: address choice; the layer entry of a term stays addressed
    // until the divider takes it
    always_comb
    begin
        kaddr = '0;
        laddr = i_reg[LW-1:0];
        lwe   = 1'b0;
        lwd   = '0;
        unique case (st_reg)
            S_CHK0:  kaddr = KW'(n_reg - 7'd1);
            S_CHK1:  kaddr = '0;
            S_SRCH0: kaddr = i_reg[KW-1:0];
            S_SRCH1: kaddr = KW'(i_reg + 7'd1);
            S_TOP0:  kaddr = KW'(k_reg);
            S_TOP1:  kaddr = KW'(k_reg + 7'd1);
            S_TERM0: begin kaddr = ga[KW-1:0]; laddr = ga[LW-1:0] - base_reg[LW-1:0]; end
            S_TERM1: begin kaddr = gb[KW-1:0]; laddr = ga[LW-1:0] - base_reg[LW-1:0]; end
            S_TERM2: laddr = ga[LW-1:0] - base_reg[LW-1:0];
            S_CLR:
            begin
                lwe = 1'b1;
                lwd = (7'(i_reg + base_reg) == k_reg) ? ONE_Q32 : '0;
            end
            S_WB:
            begin
                lwe = 1'b1;
                lwd = sat40(acc_reg);
            end
            default: ;
        endcase
    end

    // the divider starts only for a term that is not dropped
    always_comb
    begin
        mreq       = '0;
        mreq.start = (st_reg == S_TERM3) && !is_small(dfk, tol_reg);
        mreq.num   = dstep ? 34'({d_reg, 16'd0})
                   : (side_reg ? 34'(kb_reg) - 34'(t_reg) : 34'(t_reg) - 34'(ka_reg));
        mreq.val   = lq_reg;
        mreq.den   = dfk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_reg    <= 3'd3;
            cnt_reg    <= 7'd0;
            tol_reg    <= 16'd1;
            st_reg     <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_DEGREE: deg_reg <= cfg_data[2:0];
                    CFG_COUNT:  cnt_reg <= cfg_data[6:0];
                    CFG_TOL:    tol_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (start && in_item.req_type == REQ_EVAL)
                    begin
                        t_reg   <= in_item.param_t;
                        der_reg <= in_item.derivative_order;
                        n_reg   <= (cnt_reg > 7'(MAX_KNOTS)) ? 7'(MAX_KNOTS) : cnt_reg;
                        d_reg   <= deg_reg;
                        st_reg  <= S_CHK0;
                    end
                end
                S_CHK0:
                begin
                    if (n_reg < {4'd0, d_reg} + 7'd2)
                    begin
                        out_reg    <= '{status: 1'b1, basis_index: '0, basis_value: '0, last: 1'b1};
                        ovalid_reg <= 1'b1;
                        st_reg     <= S_IDLE;
                    end
                    else
                        st_reg <= S_CHK1;
                end
                S_CHK1:
                begin
                    ka_reg <= kq_reg;   // K[n-1]
                    st_reg <= S_CHK2;
                end
                S_CHK2:
                begin
                    if (is_small(33'(ka_reg) - 33'(kq_reg), tol_reg))
                    begin
                        out_reg    <= '{status: 1'b1, basis_index: '0, basis_value: '0, last: 1'b1};
                        ovalid_reg <= 1'b1;
                        st_reg     <= S_IDLE;
                    end
                    else
                    begin
                        kb_reg    <= ka_reg;  // keep K[n-1]
                        i_reg     <= '0;
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                        st_reg    <= S_SRCH0;
                    end
                end
                S_SRCH0: st_reg <= S_SRCH1;
                S_SRCH1:
                begin
                    ka_reg <= kq_reg;
                    st_reg <= S_SRCH2;
                end
                S_SRCH2:
                begin
                    if (!found_reg && (33'(t_reg) >= 33'(ka_reg) - tol_s)
                        && (33'(t_reg) < 33'(kq_reg) + tol_s) && !small_d)
                    begin
                        k_reg     <= i_reg;
                        found_reg <= 1'b1;
                    end
                    if (7'(i_reg + 7'd2) >= n_reg)
                    begin
                        if (33'(t_reg) >= 33'(kb_reg) - tol_s)
                        begin
                            k_reg  <= n_reg - 7'd2;
                            st_reg <= S_TOP0;
                        end
                        else
                            st_reg <= S_WIN;
                    end
                    else
                    begin
                        i_reg  <= i_reg + 7'd1;
                        st_reg <= S_SRCH0;
                    end
                end
                S_TOP0: st_reg <= S_TOP1;
                S_TOP1:
                begin
                    ka_reg <= kq_reg;
                    st_reg <= S_TOP2;
                end
                S_TOP2:
                begin
                    if (k_reg != 7'd0 && small_d)
                    begin
                        k_reg  <= k_reg - 7'd1;
                        st_reg <= S_TOP0;
                    end
                    else
                        st_reg <= S_WIN;
                end
                S_WIN:
                begin
                    if (k_reg > {4'd0, d_reg})
                    begin
                        base_reg  <= k_reg - {4'd0, d_reg};
                        width_reg <= ((nb - (k_reg - {4'd0, d_reg})) > {4'd0, d_reg} + 7'd1)
                                   ? {1'b0, d_reg} + 4'd1
                                   : 4'(nb - (k_reg - {4'd0, d_reg}));
                    end
                    else
                    begin
                        base_reg  <= '0;
                        width_reg <= (nb > {4'd0, d_reg} + 7'd1) ? {1'b0, d_reg} + 4'd1 : 4'(nb);
                    end
                    i_reg  <= '0;
                    st_reg <= S_CLR;
                end
                S_CLR:
                begin
                    if (7'(i_reg + 7'd1) >= {3'd0, width_reg})
                    begin
                        i_reg    <= '0;
                        p_reg    <= 3'd1;
                        side_reg <= 1'b0;
                        acc_reg  <= '0;
                        st_reg   <= (d_reg == 3'd0) ? S_OUT : S_TERM0;
                    end
                    else
                        i_reg <= i_reg + 7'd1;
                end
                S_TERM0:
                begin
                    // skip a term whose upper knot or layer entry is out of range
                    if (gb >= n_reg || (side_reg && 7'(i_reg + 7'd1) >= {3'd0, width_reg}))
                    begin
                        if (side_reg)
                            st_reg <= S_WB;
                        else
                        begin
                            left_reg <= '0;
                            side_reg <= 1'b1;
                        end
                    end
                    else
                        st_reg <= S_TERM1;
                end
                S_TERM1:
                begin
                    ka_reg <= kq_reg;
                    st_reg <= S_TERM2;
                end
                S_TERM2:
                begin
                    kb_reg <= kq_reg;
                    st_reg <= S_TERM3;
                end
                S_TERM3:
                begin
                    if (is_small(dfk, tol_reg))
                    begin
                        if (side_reg)
                            st_reg <= S_WB;
                        else
                        begin
                            left_reg <= '0;
                            side_reg <= 1'b1;
                            st_reg   <= S_TERM0;
                        end
                    end
                    else
                        st_reg <= S_MD;
                end
                S_MD:
                begin
                    if (mrsp.done)
                    begin
                        if (side_reg)
                        begin
                            acc_reg <= dstep ? 42'(left_reg) - 42'(mrsp.res)
                                             : 42'(left_reg) + 42'(mrsp.res);
                            st_reg  <= S_WB;
                        end
                        else
                        begin
                            left_reg <= mrsp.res;
                            side_reg <= 1'b1;
                            st_reg   <= S_TERM0;
                        end
                    end
                end
                S_WB:
                begin
                    side_reg <= 1'b0;
                    left_reg <= '0;
                    acc_reg  <= '0;
                    if (7'(i_reg + 7'd1) >= {3'd0, width_reg})
                    begin
                        i_reg <= '0;
                        if (p_reg == d_reg)
                            st_reg <= S_OUT;
                        else
                        begin
                            p_reg  <= p_reg + 3'd1;
                            st_reg <= S_TERM0;
                        end
                    end
                    else
                    begin
                        i_reg  <= i_reg + 7'd1;
                        st_reg <= S_TERM0;
                    end
                end
                S_OUT: st_reg <= S_OUT1;
                S_OUT1:
                begin
                    out_reg.status      <= 1'b0;
                    out_reg.basis_index <= 6'(g);
                    out_reg.basis_value <= (der_reg && d_reg == 3'd0) ? '0 : lq_reg;
                    out_reg.last        <= (7'(i_reg + 7'd1) >= {3'd0, width_reg});
                    ovalid_reg          <= 1'b1;
                    if (7'(i_reg + 7'd1) >= {3'd0, width_reg})
                        st_reg <= S_IDLE;
                    else
                    begin
                        i_reg  <= i_reg + 7'd1;
                        st_reg <= S_OUT;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
            // in S_WB a sum whose right term is dropped still writes the left term
            if (st_reg == S_TERM0 && side_reg == 1'b0 && gb >= n_reg)
                acc_reg <= '0;
            if ((st_reg == S_TERM0 || st_reg == S_TERM3) && side_reg
                && (gb >= n_reg || 7'(i_reg + 7'd1) >= {3'd0, width_reg}
                    || is_small(dfk, tol_reg)))
                acc_reg <= 42'(left_reg);
        end
    end
endmodule
`default_nettype wire
